### hw/rtl/bounded_lifo_stack_with_search_macros.svh
// Assertion macros used by the checker module of the stack block.
`ifndef BOUNDED_LIFO_STACK_WITH_SEARCH_MACROS_SVH
`define BOUNDED_LIFO_STACK_WITH_SEARCH_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define BLSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stack check failed");

// Next-cycle implication, checked only while out of reset.
`define BLSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stack check failed");

`endif

### hw/rtl/blss_pkg.sv
`default_nettype none
package blss_pkg;

    localparam int DEF_CAPACITY = 128;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 8;
    localparam int LIMIT_W      = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd128;

    localparam logic [1:0] MODE_PUSH   = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic scan_start;
        logic scan_step;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] mode;
        logic       empty;
        logic       hit;
        logic       last;
        logic       out_free;
    } t_stat;

endpackage
`default_nettype wire

### hw/rtl/blss_ctrl.sv
`default_nettype none
module blss_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire blss_pkg::t_stat i_stat,
    output blss_pkg::t_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                // A search of a non-empty stack walks the memory; all else ends here.
                if (i_stat.mode == blss_pkg::MODE_SEARCH && !i_stat.empty) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.hit || i_stat.last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/blss_dp.sv
`default_nettype none
module blss_dp #(
    parameter int CAPACITY = blss_pkg::DEF_CAPACITY
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire blss_pkg::t_cmd                i_cmd,
    output blss_pkg::t_stat                    o_stat,
    input  wire logic [1:0]                    i_mode,
    input  wire logic signed [blss_pkg::VALUE_W-1:0] i_value,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [blss_pkg::LIMIT_W-1:0]  i_cfg_data,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [1:0]                         o_status,
    output logic                               o_found,
    output logic [blss_pkg::COUNT_W-1:0]       o_entry_count,
    output logic [blss_pkg::COUNT_W-1:0]       o_free_slots
);

    localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int WIDE_W = (AW > blss_pkg::COUNT_W) ? AW : blss_pkg::COUNT_W;
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int EW     = (CW > blss_pkg::LIMIT_W) ? CW : blss_pkg::LIMIT_W;

    logic [blss_pkg::VALUE_W-1:0] mem [CAPACITY];

    logic [blss_pkg::LIMIT_W-1:0] r_limit;
    logic [blss_pkg::COUNT_W-1:0] r_count;
    logic [blss_pkg::COUNT_W-1:0] n_count;
    logic [1:0]                   r_mode;
    logic [blss_pkg::VALUE_W-1:0] r_value;
    logic [blss_pkg::COUNT_W-1:0] r_idx;
    logic [blss_pkg::VALUE_W-1:0] r_rd_data;
    logic                         r_found;
    logic                         r_out_valid;

    logic [EW-1:0]                limit_ext;
    logic [EW-1:0]                eff_ext;
    logic [blss_pkg::COUNT_W-1:0] eff_limit;
    logic                         full;
    logic [1:0]                   exec_status;
    logic                         push_ok;
    logic                         wr_en;
    logic                         rd_en;
    logic [WIDE_W-1:0]            count_wide;
    logic [WIDE_W-1:0]            idx_wide;
    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                rd_addr;
    logic [blss_pkg::COUNT_W-1:0] res_count;
    logic [blss_pkg::COUNT_W-1:0] res_free;
    logic                         load_out;

    assign o_cfg_ready = 1'b1;

    // The usable depth is the configured limit, saturated at the memory depth.
    assign limit_ext = EW'(r_limit);
    assign eff_ext   = (limit_ext > EW'(CAPACITY)) ? EW'(CAPACITY) : limit_ext;
    assign eff_limit = eff_ext[blss_pkg::COUNT_W-1:0];
    assign full      = (r_count >= eff_limit);

    assign count_wide = WIDE_W'(r_count);
    assign idx_wide   = WIDE_W'(r_idx);
    assign wr_addr    = count_wide[AW-1:0];
    assign rd_addr    = i_cmd.scan_start ? '0 : idx_wide[AW-1:0];
    assign rd_en      = i_cmd.scan_start || i_cmd.scan_step;

    always_comb begin
        n_count     = r_count;
        exec_status = blss_pkg::ST_OK;
        push_ok     = 1'b0;
        case (r_mode)
            blss_pkg::MODE_PUSH: begin
                if (full) begin
                    exec_status = blss_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 8'd1;
                    push_ok = 1'b1;
                end
            end
            blss_pkg::MODE_POP: begin
                if (r_count == '0) begin
                    exec_status = blss_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - 8'd1;
                end
            end
            blss_pkg::MODE_SEARCH: begin
                // Only the empty case reaches here; other searches scan.
                exec_status = blss_pkg::ST_EMPTY;
            end
            default: begin
                exec_status = blss_pkg::ST_OK;
            end
        endcase
    end

    assign wr_en     = i_cmd.exec && push_ok;
    assign load_out  = i_cmd.exec || i_cmd.finish;
    assign res_count = i_cmd.finish ? r_count : n_count;
    assign res_free  = (eff_limit > res_count) ? (eff_limit - res_count) : '0;

    assign o_stat.mode     = r_mode;
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.hit      = (r_rd_data == r_value);
    assign o_stat.last     = (r_idx == r_count);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode  <= i_mode;
            r_value <= i_value;
        end
        if (i_cmd.scan_start) begin
            r_idx <= 8'd1;
        end else if (i_cmd.scan_step) begin
            r_idx   <= r_idx + 8'd1;
            r_found <= o_stat.hit;
        end
        if (load_out) begin
            o_status      <= i_cmd.finish ? blss_pkg::ST_OK : exec_status;
            o_found       <= i_cmd.finish && r_found;
            o_entry_count <= res_count;
            o_free_slots  <= res_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= blss_pkg::LIMIT_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                r_count <= n_count;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

### hw/rtl/bounded_lifo_stack_with_search.sv
// Push, pop and unused modes: the result loads from the execute state once the output is free.
// Search: the entry memory has one read port, so the scan compares one held entry
// per cycle, bottom first, and stops at the first match.
// One item is in work at a time; the next is taken the cycle after its result loads.
// Synchronous active-low reset empties the stack and sets the limit to 128.
`default_nettype none
module bounded_lifo_stack_with_search #(
    parameter int CAPACITY = blss_pkg::DEF_CAPACITY
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [1:0]                           i_mode,
    input  wire logic signed [blss_pkg::VALUE_W-1:0]  i_value,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [1:0]                                o_status,
    output logic                                      o_found,
    output logic [blss_pkg::COUNT_W-1:0]              o_entry_count,
    output logic [blss_pkg::COUNT_W-1:0]              o_free_slots,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [blss_pkg::LIMIT_W-1:0]         i_cfg_data
);

    blss_pkg::t_cmd  cmd;
    blss_pkg::t_stat stat;

    blss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    blss_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_mode        (i_mode),
        .i_value       (i_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_entry_count (o_entry_count),
        .o_free_slots  (o_free_slots)
    );

endmodule
`default_nettype wire

### hw/rtl/blss_chk.sv
`default_nettype none
`include "bounded_lifo_stack_with_search_macros.svh"
module blss_chk (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [1:0]                   o_status,
    input wire logic                         o_found,
    input wire logic [blss_pkg::COUNT_W-1:0] o_entry_count,
    input wire logic [blss_pkg::COUNT_W-1:0] o_free_slots
);

    // A waiting item stays offered until it is taken.
    `BLSS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // A refused push means no slot was left.
    `BLSS_ASSERT_NOW(a_full_no_free, i_clk, i_rst_n,
        o_out_valid && o_status == blss_pkg::ST_FULL, o_free_slots == '0)

    // A refused pop or search happens only on an empty stack and never reports a hit.
    `BLSS_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n,
        o_out_valid && o_status == blss_pkg::ST_EMPTY, o_entry_count == '0 && !o_found)

    // A hit comes from a successful search of a non-empty stack.
    `BLSS_ASSERT_NOW(a_found_ok, i_clk, i_rst_n,
        o_out_valid && o_found, o_status == blss_pkg::ST_OK && o_entry_count != '0)

endmodule

bind bounded_lifo_stack_with_search blss_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_found       (o_found),
    .o_entry_count (o_entry_count),
    .o_free_slots  (o_free_slots)
);
`default_nettype wire
